FILE: sv/plac_pkg.sv
// ----------------------------------------------------------------------------
// plac_pkg
// Shared types and constants for the point light lightmap accumulator.
// ----------------------------------------------------------------------------
package plac_pkg;

    localparam int MAP_SIDE_DEF = 16;
    localparam int COORD_W      = 20;
    localparam int SIZE_W       = 24;
    localparam int COLOR_W      = 9;
    localparam int CH_W         = 8;
    localparam int TEXEL_W      = 3 * CH_W;
    localparam int IDX_W        = 8;
    localparam int CFG_W        = 60;
    localparam int CFG_IDX_W    = 3;
    localparam int CUT_W        = 40;
    localparam int C_W          = 17;          // coverage, Q.16 up to 1.0
    localparam int DIV_STEPS    = 18;          // quotient bits 17..0
    localparam int FRAC_SHIFT   = 24;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_LIGHT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 3'd4;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 40'd419430400;
    localparam logic [C_W-1:0]   C_ONE        = 17'd65536;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] light_x;
        logic signed [COORD_W-1:0] light_y;
        logic signed [COORD_W-1:0] light_z;
        logic [SIZE_W-1:0]         light_size;
        logic [COLOR_W-1:0]        color_red;
        logic [COLOR_W-1:0]        color_green;
        logic [COLOR_W-1:0]        color_blue;
        logic [IDX_W-1:0]          texel_index;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            lit;
        logic            light_used;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_CHK,
        ST_DINIT,
        ST_DIV,
        ST_CSET,
        ST_MUL1,
        ST_MUL2,
        ST_WR,
        ST_RD,
        ST_RDW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;       // capture input item
        logic sq;         // square the three distance components
        logic sum;        // add squares into distance
        logic ram_rd;     // issue texel store read
        logic item_addr;  // address from the read item, else texel counter
        logic cap_old;    // capture texel store read data
        logic div_init;
        logic div_step;
        logic c_set;
        logic mul1;
        logic mul2;
        logic wr;         // write blended texel, step position
        logic next_row;
        logic set_used;
        logic set_lit;
        logic finish;     // load output register
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       in_range;
    } status_t;

endpackage

FILE: sv/plac_ram.sv
// ----------------------------------------------------------------------------
// plac_ram
// Single port RAM, registered read, no reset on contents.
// ----------------------------------------------------------------------------
module plac_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/plac_ctrl.sv
// ----------------------------------------------------------------------------
// plac_ctrl
// Sequencer: cutoff test, texel sweep, divider steps and output handshake.
// ----------------------------------------------------------------------------
module plac_ctrl #(
    parameter int MAP_SIDE = plac_pkg::MAP_SIDE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    input  plac_pkg::status_t                     status,
    output plac_pkg::cmd_t                        cmd,
    output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]  tex_addr
);
    import plac_pkg::*;

    localparam int TEXELS = MAP_SIDE * MAP_SIDE;
    localparam int AW     = $clog2(TEXELS);
    localparam int CW     = $clog2(MAP_SIDE);
    localparam int DCW    = $clog2(DIV_STEPS);

    state_t          state_reg, state_next;
    logic            cut_reg, cut_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic            ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cut_reg    <= 1'b0;
            cnt_reg    <= '0;
            col_reg    <= '0;
            dcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cut_reg    <= cut_next;
            cnt_reg    <= cnt_next;
            col_reg    <= col_next;
            dcnt_reg   <= dcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cut_next    = cut_reg;
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        dcnt_next   = dcnt_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        in_ready    = 1'b0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (status.req)
                        REQ_LIGHT:
                        begin
                            cut_next   = 1'b1;
                            state_next = ST_SQ;
                        end
                        REQ_READ:  state_next = ST_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                cmd.ram_rd = !cut_reg;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum     = 1'b1;
                cmd.cap_old = !cut_reg;
                state_next  = cut_reg ? ST_CHK : ST_DINIT;
            end
            ST_CHK:
            begin
                if (status.in_range)
                begin
                    cmd.set_used = 1'b1;
                    cut_next     = 1'b0;
                    cnt_next     = '0;
                    col_next     = '0;
                    state_next   = ST_SQ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DIV_STEPS - 1))
                begin
                    state_next = ST_CSET;
                end
            end
            ST_CSET:
            begin
                cmd.c_set  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr       = 1'b1;
                cmd.next_row = (col_reg == CW'(MAP_SIDE - 1));
                col_next     = cmd.next_row ? '0 : col_reg + 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == AW'(TEXELS - 1))
                begin
                    cmd.set_lit = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_RD:
            begin
                cmd.ram_rd    = 1'b1;
                cmd.item_addr = 1'b1;
                state_next    = ST_RDW;
            end
            ST_RDW:
            begin
                cmd.cap_old = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.finish  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ovalid_reg;
    assign tex_addr  = cnt_reg;

endmodule

FILE: sv/plac_dpath.sv
// ----------------------------------------------------------------------------
// plac_dpath
// Config registers, patch position stepping, squared distance, serial
// coverage divider, colour blend and the texel store.
// ----------------------------------------------------------------------------
module plac_dpath #(
    parameter int MAP_SIDE = plac_pkg::MAP_SIDE_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [plac_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [plac_pkg::CFG_W-1:0]                 cfg_wdata,
    input  plac_pkg::in_item_t                         in_data,
    input  plac_pkg::cmd_t                             cmd,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]       tex_addr,
    output plac_pkg::status_t                          status,
    output plac_pkg::out_item_t                        out_data
);
    import plac_pkg::*;

    localparam int TEXELS = MAP_SIDE * MAP_SIDE;
    localparam int AW     = $clog2(TEXELS);
    localparam int CL     = $clog2(MAP_SIDE);
    localparam int POS_W  = COORD_W + 1 + CL;  // |pos| < 2^(20+CL)
    localparam int DIF_W  = POS_W + 1;
    localparam int MAG_W  = POS_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int DIV_W  = DIST_W + DIV_STEPS - 1;
    localparam int P1_W   = CH_W + C_W;
    localparam int P2_W   = P1_W + COLOR_W;

    // configuration
    logic [CFG_W-1:0] origin_reg, colstep_reg, rowstep_reg;
    logic [CH_W-1:0]  min_reg;
    logic [CUT_W-1:0] cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            colstep_reg <= '0;
            rowstep_reg <= '0;
            min_reg     <= '0;
            cutoff_reg  <= CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN:    origin_reg  <= cfg_wdata;
                CFG_COL_STEP:  colstep_reg <= cfg_wdata;
                CFG_ROW_STEP:  rowstep_reg <= cfg_wdata;
                CFG_MIN_LEVEL: min_reg     <= cfg_wdata[CH_W-1:0];
                CFG_CUTOFF:    cutoff_reg  <= cfg_wdata[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    in_item_t item_reg;
    logic     lit_reg, used_reg;

    logic signed [POS_W-1:0] org   [3];
    logic signed [POS_W-1:0] cstep [3];
    logic signed [POS_W-1:0] rstep [3];
    logic signed [DIF_W-1:0] lp    [3];
    logic [COLOR_W-1:0]      color [3];

    logic signed [POS_W-1:0] pos_reg  [3];
    logic signed [POS_W-1:0] rowb_reg [3];
    logic signed [DIF_W-1:0] diff     [3];
    logic [MAG_W-1:0]        mag      [3];
    logic [SQ_W-1:0]         sq_reg   [3];
    logic [DIST_W-1:0]       dist_reg;

    logic [TEXEL_W-1:0] old_reg;
    logic [DIV_W-1:0]   rem_reg, dsh_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [C_W-1:0]     c_reg;

    logic [CH_W-1:0]    base   [3];
    logic [CH_W-1:0]    span   [3];
    logic [P1_W-1:0]    p1_reg [3];
    logic [P2_W-1:0]    p2_reg [3];
    logic [CH_W+1:0]    sum_v  [3];
    logic [TEXEL_W-1:0] wdata;
    logic [TEXEL_W-1:0] rdata;
    logic [AW-1:0]      ram_addr;
    logic               idx_ok;

    always_comb
    begin
        lp[0]    = DIF_W'(item_reg.light_x);
        lp[1]    = DIF_W'(item_reg.light_y);
        lp[2]    = DIF_W'(item_reg.light_z);
        color[0] = item_reg.color_red;
        color[1] = item_reg.color_green;
        color[2] = item_reg.color_blue;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        assign org[k]   = POS_W'($signed(origin_reg[COORD_W*k +: COORD_W]));
        assign cstep[k] = POS_W'($signed(colstep_reg[COORD_W*k +: COORD_W]));
        assign rstep[k] = POS_W'($signed(rowstep_reg[COORD_W*k +: COORD_W]));
        assign diff[k]  = lp[k] - DIF_W'(pos_reg[k]);
        assign mag[k]   = diff[k][DIF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);

        assign base[k]  = lit_reg ? old_reg[CH_W*k +: CH_W] : min_reg;
        assign span[k]  = 8'd255 - base[k];
        assign sum_v[k] = (CH_W+2)'(base[k]) + (CH_W+2)'(p2_reg[k][P2_W-1:FRAC_SHIFT]);
        assign wdata[CH_W*k +: CH_W] = (sum_v[k] > (CH_W+2)'(255)) ? 8'd255
                                                                  : sum_v[k][CH_W-1:0];

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                pos_reg[k]  <= org[k];
                rowb_reg[k] <= org[k];
            end
            else if (cmd.wr)
            begin
                if (cmd.next_row)
                begin
                    rowb_reg[k] <= rowb_reg[k] + rstep[k];
                    pos_reg[k]  <= rowb_reg[k] + rstep[k];
                end
                else
                begin
                    pos_reg[k] <= pos_reg[k] + cstep[k];
                end
            end
            if (cmd.sq)
            begin
                sq_reg[k] <= mag[k] * mag[k];
            end
            if (cmd.mul1)
            begin
                p1_reg[k] <= P1_W'(span[k]) * P1_W'(c_reg);
            end
            if (cmd.mul2)
            begin
                p2_reg[k] <= P2_W'(p1_reg[k]) * P2_W'(color[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.sum)
        begin
            dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        end
        if (cmd.cap_old)
        begin
            old_reg <= rdata;
        end
        // restoring division, one quotient bit a step
        if (cmd.div_init)
        begin
            rem_reg <= DIV_W'({item_reg.light_size, FRAC_SHIFT'(0)});
            dsh_reg <= DIV_W'(dist_reg) << (DIV_STEPS - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[DIV_STEPS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.c_set)
        begin
            if (item_reg.light_size == '0)
            begin
                c_reg <= '0;
            end
            else if (dist_reg == '0 || q_reg >= DIV_STEPS'(C_ONE))
            begin
                c_reg <= C_ONE;
            end
            else
            begin
                c_reg <= q_reg[C_W-1:0];
            end
        end
        if (cmd.finish)
        begin
            out_data.lit        <= lit_reg;
            out_data.light_used <= used_reg;
            if (item_reg.req_type == REQ_READ && lit_reg && idx_ok)
            begin
                out_data.red   <= old_reg[CH_W*0 +: CH_W];
                out_data.green <= old_reg[CH_W*1 +: CH_W];
                out_data.blue  <= old_reg[CH_W*2 +: CH_W];
            end
            else
            begin
                out_data.red   <= '0;
                out_data.green <= '0;
                out_data.blue  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg  <= 1'b0;
            used_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                used_reg <= 1'b0;
                if (in_data.req_type == REQ_START)
                begin
                    lit_reg <= 1'b0;
                end
            end
            if (cmd.set_used)
            begin
                used_reg <= 1'b1;
            end
            if (cmd.set_lit)
            begin
                lit_reg <= 1'b1;
            end
        end
    end

    assign idx_ok   = 32'(item_reg.texel_index) < 32'(TEXELS);
    assign ram_addr = cmd.item_addr ? AW'(item_reg.texel_index) : tex_addr;

    plac_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXELS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr),
        .re    (cmd.ram_rd),
        .addr  (ram_addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign status.req      = in_data.req_type;
    assign status.in_range = dist_reg <= DIST_W'(cutoff_reg);

endmodule

FILE: sv/lightmap_point_light_accumulate.sv
// ----------------------------------------------------------------------------
// lightmap_point_light_accumulate
// Point light accumulation into a square RGB lightmap, one light at a time.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready  | in_data   (plac_pkg::in_item_t)
//   out     | out       | out_valid / out_ready| out_data  (plac_pkg::out_item_t)
//   cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//
// One transaction in gives one transaction out; one item is worked at a time.
// The texel sweep of an applied light is paced by the 18-step serial
// coverage divider and the single port texel store used once per texel.
// A finished result waits in the output register while the next item is
// taken; a result with the register still full stalls the sequencer.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module lightmap_point_light_accumulate #(
    parameter int MAP_SIDE = plac_pkg::MAP_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  plac_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output plac_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [plac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plac_pkg::CFG_W-1:0]     cfg_wdata
);
    import plac_pkg::*;

    cmd_t                                 cmd;
    status_t                              status;
    logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] tex_addr;

    plac_ctrl #(
        .MAP_SIDE (MAP_SIDE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .tex_addr  (tex_addr)
    );

    plac_dpath #(
        .MAP_SIDE (MAP_SIDE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .tex_addr  (tex_addr),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - lightmap_point_light_accumulate regression
// Drives start, light, read and unused requests through the valid/ready
// input channel, with bursty sending and a stalling receiver. A local
// lightmap predictor tracks the texels, lit flag and registers; every
// response transaction is checked field by field against the oldest one due.
// ============================================================================
module tb_top;
    import plac_pkg::*;

    localparam int SIDE   = MAP_SIDE_DEF;
    localparam int TEXELS = SIDE * SIDE;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    lightmap_point_light_accumulate #(.MAP_SIDE(SIDE)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [CFG_W-1:0]    reg_origin = '0;
    logic [CFG_W-1:0]    reg_col_step = '0;
    logic [CFG_W-1:0]    reg_row_step = '0;
    logic [CH_W-1:0]     reg_min_level = '0;
    logic [CUT_W-1:0]    reg_cutoff = CUTOFF_RESET;
    logic [TEXEL_W-1:0]  texel_mem [TEXELS];
    bit                  map_lit = 1'b0;

    out_item_t expected_texel_q[$];
    int        fail_count = 0;
    int        burst_left = 0;

    function automatic longint coord(logic [CFG_W-1:0] pk, int k);
        logic signed [COORD_W-1:0] f;
        f = pk[k*COORD_W +: COORD_W];
        return longint'(f);
    endfunction

    function automatic longint unsigned sqr(longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        return m * m;
    endfunction

    function automatic logic [CH_W-1:0] mix(int unsigned base, int unsigned span,
                                            longint unsigned cov, longint unsigned col);
        longint unsigned v;
        v = base + ((span * cov * col) >> FRAC_SHIFT);
        return (v > 255) ? 8'd255 : v[CH_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pack3(longint x, longint y, longint z);
        logic [COORD_W-1:0] a, b, c;
        a = x[COORD_W-1:0];
        b = y[COORD_W-1:0];
        c = z[COORD_W-1:0];
        return {c, b, a};
    endfunction

    // Works out the response for one accepted request and updates the map
    task automatic shade_patch(input in_item_t it);
        out_item_t       r;
        longint          lp [3];
        longint unsigned col [3];
        longint unsigned d2, dist2, cov, sz;
        longint          p;
        logic [TEXEL_W-1:0] t, nt;
        int unsigned     old;
        r = '0;
        if (it.req_type == REQ_START)
            map_lit = 1'b0;
        else if (it.req_type == REQ_LIGHT)
        begin
            lp[0] = longint'(it.light_x);
            lp[1] = longint'(it.light_y);
            lp[2] = longint'(it.light_z);
            col[0] = 64'(it.color_red);
            col[1] = 64'(it.color_green);
            col[2] = 64'(it.color_blue);
            sz = 64'(it.light_size);
            d2 = 0;
            for (int k = 0; k < 3; k++)
                d2 += sqr(lp[k] - coord(reg_origin, k));
            if (d2 <= reg_cutoff)
            begin
                r.light_used = 1'b1;
                for (int i = 0; i < SIDE; i++)
                    for (int j = 0; j < SIDE; j++)
                    begin
                        dist2 = 0;
                        for (int k = 0; k < 3; k++)
                        begin
                            p = coord(reg_origin, k) + j * coord(reg_col_step, k)
                                + i * coord(reg_row_step, k);
                            dist2 += sqr(lp[k] - p);
                        end
                        if (sz == 0)
                            cov = 0;
                        else if (dist2 == 0)
                            cov = 65536;
                        else
                        begin
                            cov = (sz << 24) / dist2;
                            if (cov > 65536) cov = 65536;
                        end
                        t = texel_mem[i*SIDE + j];
                        for (int k = 0; k < 3; k++)
                        begin
                            old = 32'(t[8*k +: 8]);
                            if (!map_lit)
                                nt[8*k +: 8] = mix(32'(reg_min_level),
                                                   32'(255) - 32'(reg_min_level),
                                                   cov, col[k]);
                            else
                                nt[8*k +: 8] = mix(old, 32'(255) - old, cov, col[k]);
                        end
                        texel_mem[i*SIDE + j] = nt;
                    end
                map_lit = 1'b1;
            end
        end
        else if (it.req_type == REQ_READ && map_lit && it.texel_index < TEXELS)
        begin
            t = texel_mem[it.texel_index];
            r.red   = t[7:0];
            r.green = t[15:8];
            r.blue  = t[23:16];
        end
        r.lit = map_lit;
        expected_texel_q.push_back(r);
    endtask

    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 4))
                @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        shade_patch(it);
        burst_left--;
    endtask

    // Registers only change with the block idle and nothing outstanding
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_texel_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN:    reg_origin    = val;
            CFG_COL_STEP:  reg_col_step  = val;
            CFG_ROW_STEP:  reg_row_step  = val;
            CFG_MIN_LEVEL: reg_min_level = val[CH_W-1:0];
            CFG_CUTOFF:    reg_cutoff    = val[CUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_patch(input logic [CFG_W-1:0] org, input logic [CFG_W-1:0] cs,
                             input logic [CFG_W-1:0] rs, input logic [CH_W-1:0] ml,
                             input logic [CUT_W-1:0] cut);
        cfg_write(CFG_ORIGIN, org);
        cfg_write(CFG_COL_STEP, cs);
        cfg_write(CFG_ROW_STEP, rs);
        cfg_write(CFG_MIN_LEVEL, {52'd0, ml});
        cfg_write(CFG_CUTOFF, {20'd0, cut});
    endtask

    function automatic in_item_t make_req(logic [1:0] req);
        in_item_t it;
        it = '0;
        it.req_type = req;
        return it;
    endfunction

    function automatic in_item_t make_light(longint x, longint y, longint z,
                                            int unsigned sz, int unsigned r,
                                            int unsigned g, int unsigned b);
        in_item_t it;
        it = make_req(REQ_LIGHT);
        it.light_x = x[COORD_W-1:0];
        it.light_y = y[COORD_W-1:0];
        it.light_z = z[COORD_W-1:0];
        it.light_size  = sz[SIZE_W-1:0];
        it.color_red   = r[COLOR_W-1:0];
        it.color_green = g[COLOR_W-1:0];
        it.color_blue  = b[COLOR_W-1:0];
        return it;
    endfunction

    function automatic in_item_t make_read(int unsigned idx);
        in_item_t it;
        it = make_req(REQ_READ);
        it.texel_index = idx[IDX_W-1:0];
        return it;
    endfunction

    // Random request: mostly reads, plus starts, lights near the patch and noise
    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned pick;
        longint      ox, oy, oz;
        int unsigned sz;
        logic [127:0] raw;
        pick = $urandom_range(0, 99);
        ox = coord(reg_origin, 0);
        oy = coord(reg_origin, 1);
        oz = coord(reg_origin, 2);
        raw = {$urandom, $urandom, $urandom, $urandom};
        if (pick < 7)
        begin
            it = make_req(REQ_START);
            it.texel_index = IDX_W'($urandom);
        end
        else if (pick < 17)
        begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                             : $urandom_range(0, 1 << 17);
            it = make_light(ox + $signed($urandom_range(0, 10240)) - 5120,
                            oy + $signed($urandom_range(0, 10240)) - 5120,
                            oz + $signed($urandom_range(0, 10240)) - 5120, sz,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                      : $urandom_range(0, 256),
                            $urandom_range(0, 256), $urandom_range(0, 256));
            if ($urandom_range(0, 9) == 0) it.color_green = COLOR_W'($urandom_range(0, 511));
            if ($urandom_range(0, 9) == 0) it.color_blue  = COLOR_W'($urandom_range(0, 511));
        end
        else if (pick < 25)
        begin
            // far-away light, full field range; mostly skipped by the cutoff
            it = raw[$bits(in_item_t)-1:0];
            it.req_type = REQ_LIGHT;
        end
        else if (pick < 28)
        begin
            it = raw[$bits(in_item_t)-1:0];
            it.req_type = REQ_UNUSED;
        end
        else
        begin
            it = raw[$bits(in_item_t)-1:0];
            it.req_type = REQ_READ;
        end
        return it;
    endfunction

    task automatic test_reset_state();
        send_item(make_read(0));
        send_item(make_read(255));
        send_item(make_req(REQ_UNUSED));
    endtask

    task automatic test_directed_cases();
        set_patch(pack3(256, -512, 1024), pack3(256, 0, 0), pack3(0, 256, 0), 8'd40,
                  CUTOFF_RESET);
        // zero size as first light leaves every texel at the floor level
        send_item(make_light(256, -512, 1024, 0, 256, 256, 256));
        send_item(make_read(0));
        send_item(make_read(17));
        // light on a texel: zero distance there
        send_item(make_light(256 + 3*256, -512 + 2*256, 1024, 5000, 256, 128, 0));
        send_item(make_read(2*SIDE + 3));
        send_item(make_read(255));
        // colour above 1.0 saturates
        send_item(make_light(256, -512, 1024 + 512, 24'hFFFFFF, 511, 511, 300));
        send_item(make_read(0));
        // beyond the cutoff: not applied
        send_item(make_light(-524288, 524287, -524288, 1000, 256, 256, 256));
        send_item(make_req(REQ_UNUSED));
        send_item(make_req(REQ_START));
        send_item(make_read(5));
        send_item(make_light(1000, -900, 1100, 20000, 0, 256, 100));
        send_item(make_read(128));
        send_item(make_read(255));
    endtask

    task automatic test_config_extremes();
        // all-ones fields, cutoff zero: only a light exactly at the corner lands
        set_patch({CFG_W{1'b1}}, pack3(524287, -524288, 524287),
                  pack3(-524288, 524287, -524288), 8'd255, '0);
        send_item(make_req(REQ_START));
        send_item(make_light(1, -1, -1, 100, 256, 256, 256));
        send_item(make_light(-1, -1, -1, 24'hFFFFFF, 256, 1, 511));
        send_item(make_read(0));
        send_item(make_read(255));
        set_patch(pack3(524287, 524287, 524287), '0, pack3(1, -1, 1), 8'd0,
                  {CUT_W{1'b1}});
        send_item(make_req(REQ_START));
        send_item(make_light(-524288, -524288, -524288, 24'hFFFFFF, 256, 256, 256));
        send_item(make_light(524287, 524287, 524287, 1, 511, 0, 256));
        send_item(make_read(1));
        send_item(make_read(200));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++)
        begin
            set_patch(pack3($signed($urandom_range(0, 8192)) - 4096,
                            $signed($urandom_range(0, 8192)) - 4096,
                            $signed($urandom_range(0, 8192)) - 4096),
                      pack3($signed($urandom_range(0, 512)) - 256,
                            $signed($urandom_range(0, 512)) - 256,
                            $signed($urandom_range(0, 512)) - 256),
                      pack3($signed($urandom_range(0, 512)) - 256,
                            $signed($urandom_range(0, 512)) - 256,
                            $signed($urandom_range(0, 512)) - 256),
                      CH_W'($urandom_range(0, 255)),
                      (ph == 3) ? 40'd0 : (ph == 7) ? {CUT_W{1'b1}}
                                                    : CUTOFF_RESET);
            send_item(make_req(REQ_START));
            for (int n = 0; n < 160; n++)
                send_item(rand_item());
        end
    endtask

    // Receiver stall pattern: stretches of always-ready and of random stalls
    int stall_len = 0;
    bit stall_mode = 1'b0;
    always @(negedge clk)
    begin
        if (stall_len == 0)
        begin
            stall_mode = 1'($urandom_range(0, 1));
            stall_len  = $urandom_range(5, 200);
        end
        stall_len--;
        out_ready <= stall_mode ? ($urandom_range(0, 3) != 0 && $urandom_range(0, 40) != 0)
                                : 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_texel_q.size() == 0)
            begin
                $display("%0t: unexpected response transaction, actual %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                e = expected_texel_q.pop_front();
                if (out_data.red !== e.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, e.red, out_data.red);
                    fail_count++;
                end
                if (out_data.green !== e.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, e.green,
                             out_data.green);
                    fail_count++;
                end
                if (out_data.blue !== e.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, e.blue, out_data.blue);
                    fail_count++;
                end
                if (out_data.lit !== e.lit)
                begin
                    $display("%0t: lit expected %0d actual %0d", $time, e.lit, out_data.lit);
                    fail_count++;
                end
                if (out_data.light_used !== e.light_used)
                begin
                    $display("%0t: light_used expected %0d actual %0d", $time, e.light_used,
                             out_data.light_used);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #600ms;
        $display("lightmap_point_light_accumulate regression: fail");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);
        test_reset_state();
        test_directed_cases();
        test_config_extremes();
        test_random_traffic();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_texel_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("lightmap_point_light_accumulate regression: pass");
        else
            $display("lightmap_point_light_accumulate regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
sv/plac_pkg.sv
sv/plac_ram.sv
sv/plac_ctrl.sv
sv/plac_dpath.sv
sv/lightmap_point_light_accumulate.sv
verif/tb_top.sv
